/* hw/rtl/sdhf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdhf_pkg: spring-damped heading follower definitions
// Fixed-point formats, spring constants per needle and small helper functions.
// ----------------------------------------------------------------------------
package sdhf_pkg;

	localparam int ANGLE_FRAC_BITS = 10;
	localparam int SUBSTEP_MS      = 5;
	localparam int MAX_GAP_MS      = 500;

	localparam int ONE       = 1 << ANGLE_FRAC_BITS;
	localparam int FULL_TURN = 360 * ONE;
	localparam int HALF_TURN = 180 * ONE;
	localparam int CLAMP_ERR = 10 * ONE;

	localparam int HEAD_W  = 19;
	localparam int RATE_W  = 26;
	localparam int PRATE_W = 22;
	localparam int TIME_W  = 31;
	localparam int DIFF_W  = 20;
	localparam int TOT_W   = 9;
	localparam int DT_W    = 3;
	localparam int AMT_W   = 14;
	localparam int MA_W    = 30;
	localparam int MB_W    = 31;
	localparam int PROD_W  = MA_W + MB_W;
	localparam int Q_W     = 21;
	localparam int K_W     = 8;

	// compass (C_) and pointer (P_) spring sets
	localparam int C_ACCEL = 1000;
	localparam int P_ACCEL = 1500;
	localparam int C_DAMP  = 20;
	localparam int P_DAMP  = 30;
	localparam int C_BRAKE = 35;
	localparam int P_BRAKE = 50;
	localparam int C_FRIC  = 1;
	localparam int P_FRIC  = 2;
	localparam int C_LIMIT = 30000;
	localparam int P_LIMIT = 2000;
	localparam int C_SET_DIFF = ONE / 4;
	localparam int C_SET_RATE = ONE;
	localparam int P_SET_DIFF = ONE / 2;
	localparam int P_SET_RATE = 2 * ONE;

	// floor(y/d) = (y*M) >> S, exact for y < 2^30; /1000 = >>3 then /125,
	// /10000 = >>4 then /625
	localparam logic [MB_W-1:0] RECIP_125 = 31'd1099511628;
	localparam logic [MB_W-1:0] RECIP_625 = 31'd1759218605;

	typedef logic        [HEAD_W-1:0] head_t;
	typedef logic signed [RATE_W-1:0] rate_t;
	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic        [AMT_W-1:0]  amt_t;

	localparam amt_t C_ACC_TAB [0:7] = '{
		amt_t'(0),
		amt_t'((C_ACCEL * 1 * ONE) / 1000), amt_t'((C_ACCEL * 2 * ONE) / 1000),
		amt_t'((C_ACCEL * 3 * ONE) / 1000), amt_t'((C_ACCEL * 4 * ONE) / 1000),
		amt_t'((C_ACCEL * 5 * ONE) / 1000), amt_t'(0), amt_t'(0)};
	localparam amt_t P_ACC_TAB [0:7] = '{
		amt_t'(0),
		amt_t'((P_ACCEL * 1 * ONE) / 1000), amt_t'((P_ACCEL * 2 * ONE) / 1000),
		amt_t'((P_ACCEL * 3 * ONE) / 1000), amt_t'((P_ACCEL * 4 * ONE) / 1000),
		amt_t'((P_ACCEL * 5 * ONE) / 1000), amt_t'(0), amt_t'(0)};
	localparam amt_t C_FRIC_TAB [0:7] = '{
		amt_t'(0),
		amt_t'((C_FRIC * 1 * ONE) / 1000), amt_t'((C_FRIC * 2 * ONE) / 1000),
		amt_t'((C_FRIC * 3 * ONE) / 1000), amt_t'((C_FRIC * 4 * ONE) / 1000),
		amt_t'((C_FRIC * 5 * ONE) / 1000), amt_t'(0), amt_t'(0)};
	localparam amt_t P_FRIC_TAB [0:7] = '{
		amt_t'(0),
		amt_t'((P_FRIC * 1 * ONE) / 1000), amt_t'((P_FRIC * 2 * ONE) / 1000),
		amt_t'((P_FRIC * 3 * ONE) / 1000), amt_t'((P_FRIC * 4 * ONE) / 1000),
		amt_t'((P_FRIC * 5 * ONE) / 1000), amt_t'(0), amt_t'(0)};

	function automatic amt_t acc_amt(input logic md, input logic [DT_W-1:0] dt);
		return md ? P_ACC_TAB[dt] : C_ACC_TAB[dt];
	endfunction

	// friction, floor/cap at zero, then saturate to the needle's limit
	function automatic rate_t rate_finish(input logic signed [RATE_W:0] r, input logic md,
			input logic [DT_W-1:0] dt);
		logic signed [RATE_W:0] f;
		logic signed [RATE_W:0] lim;
		logic signed [RATE_W:0] t;
		f   = $signed({{(RATE_W+1-AMT_W){1'b0}}, (md ? P_FRIC_TAB[dt] : C_FRIC_TAB[dt])});
		lim = md ? (RATE_W+1)'(P_LIMIT * ONE) : (RATE_W+1)'(C_LIMIT * ONE);
		if (r > 0) begin
			t = r - f;
			if (t < 0) t = '0;
		end else begin
			t = r + f;
			if (t > 0) t = '0;
		end
		if (t > lim) t = lim;
		else if (t < -lim) t = -lim;
		return $signed(t[RATE_W-1:0]);
	endfunction

endpackage

/* hw/rtl/spring_damped_heading_follower_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spring_damped_heading_follower_unit
// Moves a compass or pointer needle toward its target heading with a damped
// spring, in 5 ms substeps, on one shared multiplier.
// ----------------------------------------------------------------------------
// One transaction per item, one result per item. The input stalls from
// acceptance until the result is loaded into the output register. A snap,
// a disabled pointer or a pointer zero gap goes straight to the output
// state; a compass zero gap first passes through prep, step and finish. A
// springy update runs one substep per 5 ms of the time gap (up to 100
// substeps at a 500 ms gap), fewer if the needle settles early. Each
// substep shares the single 30x31 multiplier and runs two truncating
// divisions, three when the brake term applies, each as two multiplies in sequence.
module spring_damped_heading_follower_unit
	import sdhf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              mode,
	input  logic [TIME_W-1:0] now_ms,
	input  logic [HEAD_W-1:0] view_heading,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [HEAD_W-1:0] needle_heading,
	output logic [RATE_W-1:0] needle_rate,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [HEAD_W-1:0] cfg_data
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PREP = 3'd1;
	localparam logic [2:0] ST_STEP = 3'd2;
	localparam logic [2:0] ST_MA   = 3'd3;
	localparam logic [2:0] ST_MB   = 3'd4;
	localparam logic [2:0] ST_MC   = 3'd5;
	localparam logic [2:0] ST_FIN  = 3'd6;
	localparam logic [2:0] ST_OUT  = 3'd7;

	localparam logic [1:0] OP_DIFF  = 2'd0;
	localparam logic [1:0] OP_DAMP  = 2'd1;
	localparam logic [1:0] OP_BRAKE = 2'd2;

	localparam logic        CFG_NORTH   = 1'b0;
	localparam logic        CFG_SPRINGY = 1'b1;

	localparam head_t              FULL19 = HEAD_W'(FULL_TURN);
	localparam logic signed [21:0] FULL22 = 22'(FULL_TURN);
	localparam logic signed [21:0] HALF22 = 22'(HALF_TURN);
	localparam diff_t              CLAMPD = DIFF_W'(CLAMP_ERR);
	localparam logic signed [31:0] GAP_MAX = 32'(MAX_GAP_MS);
	localparam logic [TOT_W-1:0]   SUB_T  = TOT_W'(SUBSTEP_MS);

	logic [2:0]        state_q;
	logic [1:0]        op_q;
	logic              mode_q;
	head_t             target_q;
	diff_t             diff_q;
	rate_t             rate_q;
	logic [TOT_W-1:0]  total_q;
	logic [DT_W-1:0]   dt_q;
	logic              rneg_q;
	logic [PROD_W-1:0] prod_q;

	head_t             north_q;
	logic              springy_q;
	logic [TIME_W-1:0] last_q;
	head_t             c_head_q;
	rate_t             c_rate_q;
	head_t             p_head_q;
	logic signed [PRATE_W-1:0] p_rate_q;

	logic              out_valid_q;
	head_t             out_head_q;
	rate_t             out_rate_q;

	// input side
	head_t              view_w, north_w, tgt_c, target_in;
	logic signed [19:0] tdiff;
	logic signed [31:0] gap;
	logic               gap_bad;

	always_comb begin
		view_w  = (view_heading >= FULL19) ? view_heading - FULL19 : view_heading;
		north_w = (north_q >= FULL19) ? north_q - FULL19 : north_q;
		tdiff   = $signed({1'b0, view_w}) - $signed({1'b0, north_w});
		tgt_c   = (tdiff < 0) ? HEAD_W'(tdiff + 20'(FULL_TURN)) : HEAD_W'(tdiff);
		target_in = mode ? view_w : tgt_c;
		gap     = $signed({1'b0, now_ms}) - $signed({1'b0, last_q});
		gap_bad = (gap < 0) || (gap > GAP_MAX);
	end

	// prep: initial error
	head_t              head_sel;
	logic signed [21:0] d0, d0w;
	diff_t              d0c;
	always_comb begin
		head_sel = mode_q ? p_head_q : c_head_q;
		d0 = $signed({3'b0, head_sel}) - $signed({3'b0, target_q});
		if (d0 > HALF22) d0w = d0 - FULL22;
		else if (d0 <= -HALF22) d0w = d0 + FULL22;
		else d0w = d0;
		d0c = d0w[DIFF_W-1:0];
		if (mode_q) begin
			if (d0c > CLAMPD) d0c = CLAMPD;
			else if (d0c < -CLAMPD) d0c = -CLAMPD;
		end
	end

	// substep control
	logic [DT_W-1:0]   dt_c;
	logic [DIFF_W-1:0] diff_mag;
	logic [RATE_W-1:0] rate_mag;
	logic              settled;
	always_comb begin
		dt_c     = (total_q > SUB_T) ? DT_W'(SUBSTEP_MS) : total_q[DT_W-1:0];
		diff_mag = diff_q[DIFF_W-1] ? DIFF_W'(-diff_q) : DIFF_W'(diff_q);
		rate_mag = rate_q[RATE_W-1] ? RATE_W'(-rate_q) : RATE_W'(rate_q);
		if (mode_q)
			settled = (diff_mag < DIFF_W'(P_SET_DIFF)) && (rate_mag < RATE_W'(P_SET_RATE));
		else
			settled = (diff_mag < DIFF_W'(C_SET_DIFF)) && (rate_mag < RATE_W'(C_SET_RATE));
	end

	// shared multiplier operand select
	logic [K_W-1:0]  kc, kval;
	logic [MA_W-1:0] mul_a;
	logic [MB_W-1:0] mul_b;
	always_comb begin
		if (op_q == OP_BRAKE) kc = mode_q ? K_W'(P_BRAKE) : K_W'(C_BRAKE);
		else                  kc = mode_q ? K_W'(P_DAMP) : K_W'(C_DAMP);
		kval = K_W'(kc * {{(K_W-DT_W){1'b0}}, dt_q});
		unique case (state_q)
			ST_STEP: begin
				mul_a = MA_W'(rate_mag[RATE_W-2:0]);
				mul_b = MB_W'(dt_c);
			end
			ST_MA: begin
				mul_a = MA_W'(rate_mag[RATE_W-2:0]);
				mul_b = MB_W'(kval);
			end
			ST_MB: begin
				mul_a = (op_q == OP_DIFF) ? prod_q[32:3] : prod_q[33:4];
				mul_b = (op_q == OP_DIFF) ? RECIP_125 : RECIP_625;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// quotient and the updates that use it
	logic [Q_W-1:0]     q;
	logic signed [21:0] sq, dn, dnw, hsum;
	logic signed [RATE_W:0] r_ext, r_acc, rd;
	logic signed [RATE_W:0] acc_s;
	logic               brake;
	head_t              h_fin;
	always_comb begin
		q  = (op_q == OP_DIFF) ? prod_q[57:37] : prod_q[60:40];
		sq = rneg_q ? -$signed({1'b0, q}) : $signed({1'b0, q});
		dn = $signed({{2{diff_q[DIFF_W-1]}}, diff_q}) + sq;
		if (dn > HALF22) dnw = dn - FULL22;
		else if (dn <= -HALF22) dnw = dn + FULL22;
		else dnw = dn;
		acc_s = $signed({{(RATE_W+1-AMT_W){1'b0}}, acc_amt(mode_q, dt_q)});
		r_ext = {rate_q[RATE_W-1], rate_q};
		if (dnw > 0) r_acc = r_ext - acc_s;
		else if (dnw < 0) r_acc = r_ext + acc_s;
		else r_acc = r_ext;
		rd = r_ext - (RATE_W+1)'(sq);
		brake = ((rd > 0) && (diff_q > 0)) || ((rd <= 0) && (diff_q < 0));
		hsum = $signed({{2{diff_q[DIFF_W-1]}}, diff_q}) + $signed({3'b0, target_q});
		if (hsum < 0) h_fin = HEAD_W'(hsum + FULL22);
		else if (hsum >= FULL22) h_fin = HEAD_W'(hsum - FULL22);
		else h_fin = HEAD_W'(hsum);
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			op_q      <= OP_DIFF;
			mode_q    <= 1'b0;
			target_q  <= '0;
			diff_q    <= '0;
			rate_q    <= '0;
			dt_q      <= '0;
			rneg_q    <= 1'b0;
			total_q   <= '0;
			north_q   <= '0;
			springy_q <= 1'b0;
			last_q    <= '0;
			c_head_q  <= '0;
			c_rate_q  <= '0;
			p_head_q  <= '0;
			p_rate_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_NORTH:   north_q   <= cfg_data;
					CFG_SPRINGY: springy_q <= cfg_data[0];
					default: ;
				endcase
			end
			// ST_OUT reloads the register itself when the output drains
			if (out_valid_q && !out_stall && (state_q != ST_OUT)) out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						mode_q   <= mode;
						target_q <= target_in;
						if (mode && !springy_q) begin
							p_head_q <= view_w;
							state_q  <= ST_OUT;
						end else if (mode && (last_q == now_ms)) begin
							state_q <= ST_OUT;
						end else begin
							last_q <= now_ms;
							if (gap_bad) begin
								if (mode) begin
									p_head_q <= target_in;
									p_rate_q <= '0;
								end else begin
									c_head_q <= target_in;
									c_rate_q <= '0;
								end
								state_q <= ST_OUT;
							end else begin
								total_q <= gap[TOT_W-1:0];
								state_q <= ST_PREP;
							end
						end
					end
				end
				ST_PREP: begin
					diff_q  <= d0c;
					rate_q  <= mode_q ? RATE_W'(p_rate_q) : c_rate_q;
					state_q <= ST_STEP;
				end
				ST_STEP: begin
					if (total_q == '0) begin
						state_q <= ST_FIN;
					end else if (settled) begin
						if (mode_q) begin
							p_head_q <= target_q;
							p_rate_q <= '0;
						end else begin
							c_head_q <= target_q;
							c_rate_q <= '0;
						end
						state_q <= ST_OUT;
					end else begin
						dt_q    <= dt_c;
						total_q <= total_q - TOT_W'(dt_c);
						op_q    <= OP_DIFF;
						rneg_q  <= rate_q[RATE_W-1];
						state_q <= ST_MB;
					end
				end
				ST_MA: begin
					rneg_q  <= rate_q[RATE_W-1];
					state_q <= ST_MB;
				end
				ST_MB: state_q <= ST_MC;
				ST_MC: begin
					case (op_q)
						OP_DIFF: begin
							diff_q  <= dnw[DIFF_W-1:0];
							rate_q  <= r_acc[RATE_W-1:0];
							op_q    <= OP_DAMP;
							state_q <= ST_MA;
						end
						OP_DAMP: begin
							if (brake) begin
								rate_q  <= rd[RATE_W-1:0];
								op_q    <= OP_BRAKE;
								state_q <= ST_MA;
							end else begin
								rate_q  <= rate_finish(rd, mode_q, dt_q);
								state_q <= ST_STEP;
							end
						end
						default: begin
							rate_q  <= rate_finish(rd, mode_q, dt_q);
							state_q <= ST_STEP;
						end
					endcase
				end
				ST_FIN: begin
					if (mode_q) begin
						p_head_q <= h_fin;
						p_rate_q <= rate_q[PRATE_W-1:0];
					end else begin
						c_head_q <= h_fin;
						c_rate_q <= rate_q;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output payload loads with the result transaction
	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT) && (!out_valid_q || !out_stall)) begin
			out_head_q <= mode_q ? p_head_q : c_head_q;
			out_rate_q <= mode_q ? RATE_W'(p_rate_q) : c_rate_q;
		end
	end

	assign in_stall       = (state_q != ST_IDLE);
	assign cfg_ready      = 1'b1;
	assign out_valid      = out_valid_q;
	assign needle_heading = out_head_q;
	assign needle_rate    = out_rate_q;

endmodule
